FILE: rtl/core/dcfb_pkg.sv
//------------------------------------------------------------------------------
// dcfb_pkg
// Shared widths, codes and control-word types of the command frame builder.
//------------------------------------------------------------------------------
`default_nettype none

package dcfb_pkg;

	localparam int MAX_DIGITS = 10;
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	localparam int BYTE_W     = 8;
	localparam int VAL_W      = 32;
	localparam int DCNT_W     = 4;
	localparam int CFG_IDX_W  = 4;
	localparam int PC_W       = 4;
	localparam int SRC_W      = 3;
	localparam int JMP_W      = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELIM = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STX   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ETX   = 4'd3;

	localparam logic [BYTE_W-1:0] RST_DELIM = 8'd127;
	localparam logic [BYTE_W-1:0] RST_STX   = 8'd2;
	localparam logic [BYTE_W-1:0] RST_GROUP = 8'd6;
	localparam logic [BYTE_W-1:0] RST_ETX   = 8'd3;

	// microprogram steps
	localparam logic [PC_W-1:0] STEP_WAIT   = 4'd0;
	localparam logic [PC_W-1:0] STEP_DIVM   = 4'd1;
	localparam logic [PC_W-1:0] STEP_DIVR   = 4'd2;
	localparam logic [PC_W-1:0] STEP_DELIM  = 4'd3;
	localparam logic [PC_W-1:0] STEP_START  = 4'd4;
	localparam logic [PC_W-1:0] STEP_ADDR   = 4'd5;
	localparam logic [PC_W-1:0] STEP_ADDRC  = 4'd6;
	localparam logic [PC_W-1:0] STEP_CMD    = 4'd7;
	localparam logic [PC_W-1:0] STEP_CMDC   = 4'd8;
	localparam logic [PC_W-1:0] STEP_DIG    = 4'd9;
	localparam logic [PC_W-1:0] STEP_DIGC   = 4'd10;
	localparam logic [PC_W-1:0] STEP_ETX1   = 4'd11;
	localparam logic [PC_W-1:0] STEP_ETX2   = 4'd12;
	localparam logic [PC_W-1:0] STEP_CHECK  = 4'd13;

	// byte sources
	localparam logic [SRC_W-1:0] SRC_DELIM = 3'd0;
	localparam logic [SRC_W-1:0] SRC_START = 3'd1;
	localparam logic [SRC_W-1:0] SRC_ADDR  = 3'd2;
	localparam logic [SRC_W-1:0] SRC_CMD   = 3'd3;
	localparam logic [SRC_W-1:0] SRC_DIGIT = 3'd4;
	localparam logic [SRC_W-1:0] SRC_PAIRC = 3'd5;
	localparam logic [SRC_W-1:0] SRC_ETX   = 3'd6;
	localparam logic [SRC_W-1:0] SRC_CHECK = 3'd7;

	// jump conditions
	localparam logic [JMP_W-1:0] JMP_NONE     = 3'd0;
	localparam logic [JMP_W-1:0] JMP_ALWAYS   = 3'd1;
	localparam logic [JMP_W-1:0] JMP_NODIG    = 3'd2;
	localparam logic [JMP_W-1:0] JMP_DIV_MORE = 3'd3;
	localparam logic [JMP_W-1:0] JMP_DIG_MORE = 3'd4;

	typedef struct packed {
		logic             take_req;
		logic             emit;
		logic             div_mul;
		logic             div_rem;
		logic             load_pair;
		logic             xor_etx;
		logic             dig_dec;
		logic             last;
		logic [SRC_W-1:0] src;
		logic [JMP_W-1:0] jmp;
		logic [PC_W-1:0]  target;
	} ctl_t;

	typedef struct packed {
		logic nodig;
		logic div_more;
		logic dig_more;
	} stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/dcfb_if.sv
//------------------------------------------------------------------------------
// dcfb_if
// Request and frame-byte channels with valid/ready transfer.
//------------------------------------------------------------------------------
`default_nettype none

interface dcfb_req_if;
	import dcfb_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] channel;
	logic [BYTE_W-1:0] cmd_byte;
	logic [VAL_W-1:0]  value;
	logic [DCNT_W-1:0] digit_count;
	modport source(output valid, channel, cmd_byte, value, digit_count, input ready);
	modport sink(input valid, channel, cmd_byte, value, digit_count, output ready);
endinterface

interface dcfb_frame_if;
	import dcfb_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic              last_of_frame;
	modport source(output valid, frame_byte, last_of_frame, input ready);
	modport sink(input valid, frame_byte, last_of_frame, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dcfb_ucode_rom.sv
//------------------------------------------------------------------------------
// dcfb_ucode_rom
// Microprogram table: one control word per step of the frame sequencer.
//------------------------------------------------------------------------------
`default_nettype none

module dcfb_ucode_rom (
	input  wire logic [dcfb_pkg::PC_W-1:0] pc,
	output dcfb_pkg::ctl_t                 ctl
);
	import dcfb_pkg::*;

	always_comb begin
		ctl = '0;
		unique case (pc)
			STEP_WAIT: begin
				ctl.take_req = 1'b1;
			end
			STEP_DIVM: begin
				ctl.div_mul = 1'b1;
				ctl.jmp     = JMP_NODIG;
				ctl.target  = STEP_DELIM;
			end
			STEP_DIVR: begin
				ctl.div_rem = 1'b1;
				ctl.jmp     = JMP_DIV_MORE;
				ctl.target  = STEP_DIVM;
			end
			STEP_DELIM: begin
				ctl.emit = 1'b1;
				ctl.src  = SRC_DELIM;
			end
			STEP_START: begin
				ctl.emit = 1'b1;
				ctl.src  = SRC_START;
			end
			STEP_ADDR: begin
				ctl.emit      = 1'b1;
				ctl.load_pair = 1'b1;
				ctl.src       = SRC_ADDR;
			end
			STEP_ADDRC: begin
				ctl.emit = 1'b1;
				ctl.src  = SRC_PAIRC;
			end
			STEP_CMD: begin
				ctl.emit      = 1'b1;
				ctl.load_pair = 1'b1;
				ctl.src       = SRC_CMD;
			end
			STEP_CMDC: begin
				ctl.emit   = 1'b1;
				ctl.src    = SRC_PAIRC;
				ctl.jmp    = JMP_NODIG;
				ctl.target = STEP_ETX1;
			end
			STEP_DIG: begin
				ctl.emit      = 1'b1;
				ctl.load_pair = 1'b1;
				ctl.src       = SRC_DIGIT;
			end
			STEP_DIGC: begin
				ctl.emit    = 1'b1;
				ctl.dig_dec = 1'b1;
				ctl.src     = SRC_PAIRC;
				ctl.jmp     = JMP_DIG_MORE;
				ctl.target  = STEP_DIG;
			end
			STEP_ETX1: begin
				ctl.emit    = 1'b1;
				ctl.xor_etx = 1'b1;
				ctl.src     = SRC_ETX;
			end
			STEP_ETX2: begin
				ctl.emit = 1'b1;
				ctl.src  = SRC_ETX;
			end
			STEP_CHECK: begin
				ctl.emit   = 1'b1;
				ctl.last   = 1'b1;
				ctl.src    = SRC_CHECK;
				ctl.jmp    = JMP_ALWAYS;
				ctl.target = STEP_WAIT;
			end
			default: begin
				ctl.jmp    = JMP_ALWAYS;
				ctl.target = STEP_WAIT;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/dcfb_datapath.sv
//------------------------------------------------------------------------------
// dcfb_datapath
// Config registers, request latch, divide-by-ten digit unit, digit store,
// pair/check registers and frame byte select.
//------------------------------------------------------------------------------
`default_nettype none

module dcfb_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dcfb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dcfb_pkg::BYTE_W-1:0]    cfg_data,
	input  wire logic                           req_fire,
	input  wire logic [dcfb_pkg::BYTE_W-1:0]    channel,
	input  wire logic [dcfb_pkg::BYTE_W-1:0]    cmd_byte,
	input  wire logic [dcfb_pkg::VAL_W-1:0]     value,
	input  wire logic [dcfb_pkg::DCNT_W-1:0]    digit_count,
	input  dcfb_pkg::ctl_t                      ctl,
	input  wire logic                           step_go,
	output logic [dcfb_pkg::BYTE_W-1:0]         byte_out,
	output dcfb_pkg::stat_t                     stat
);
	import dcfb_pkg::*;

	localparam int POW_W  = 34;
	localparam int QUOT_W = 29;
	localparam int PROD_W = 2 * VAL_W;
	localparam int RSHIFT = 35;
	localparam logic [VAL_W-1:0]  RECIP10   = 32'hCCCC_CCCD;
	localparam logic [BYTE_W-1:0] RECIP15   = 8'd137;
	localparam logic [BYTE_W-1:0] COMP_MASK = 8'h7F;
	localparam logic [BYTE_W-1:0] CHK_MARK  = 8'h40;
	localparam logic [3:0]        ADDR_HI   = 4'h2;
	localparam logic [3:0]        DIGIT_HI  = 4'h3;

	function automatic logic [POW_W-1:0] pow10(input logic [DCNT_W-1:0] d);
		case (d)
			4'd0:    pow10 = 34'd1;
			4'd1:    pow10 = 34'd10;
			4'd2:    pow10 = 34'd100;
			4'd3:    pow10 = 34'd1000;
			4'd4:    pow10 = 34'd10000;
			4'd5:    pow10 = 34'd100000;
			4'd6:    pow10 = 34'd1000000;
			4'd7:    pow10 = 34'd10000000;
			4'd8:    pow10 = 34'd100000000;
			4'd9:    pow10 = 34'd1000000000;
			default: pow10 = 34'd10000000000;
		endcase
	endfunction

	logic [BYTE_W-1:0] delim_q, stx_q, group_q, etx_q;
	logic [BYTE_W-1:0] addr_q, start_q, cmd_q, pair_q, check_q;
	logic [VAL_W-1:0]  val_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]  ndig_q, k_q, k_dec;
	logic [3:0]        digits_q [MAX_DIGITS];

	// request decode
	logic [DCNT_W-1:0]   dsat;
	logic [POW_W-1:0]    pw, pwm1;
	logic [VAL_W-1:0]    vclamp;
	logic [2*BYTE_W-1:0] ch_prod;
	logic [4:0]          grp;
	logic [3:0]          ch_rem, addr_lo;

	always_comb begin
		dsat    = (digit_count > DCNT_W'(MAX_DIGITS)) ? DCNT_W'(MAX_DIGITS) : digit_count;
		pw      = pow10(dsat);
		pwm1    = pw - POW_W'(1);
		vclamp  = ({{(POW_W-VAL_W){1'b0}}, value} >= pw) ? pwm1[VAL_W-1:0] : value;
		ch_prod = {{BYTE_W{1'b0}}, channel} * {{BYTE_W{1'b0}}, RECIP15};
		grp     = ch_prod[15:11];
		ch_rem  = channel[3:0] + grp[3:0];
		addr_lo = (channel < 8'd16) ? channel[3:0] : ch_rem;
	end

	// divide by ten
	logic [PROD_W-1:0] prod;
	logic [3:0]        tenq_lo, rem;

	always_comb begin
		prod    = {{VAL_W{1'b0}}, val_q} * {{VAL_W{1'b0}}, RECIP10};
		tenq_lo = {quot_q[0], 3'b000} + {quot_q[2:0], 1'b0};
		rem     = val_q[3:0] - tenq_lo;
		k_dec   = k_q - CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= RST_DELIM;
			stx_q   <= RST_STX;
			group_q <= RST_GROUP;
			etx_q   <= RST_ETX;
			k_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DELIM: delim_q <= cfg_data;
					REG_STX:   stx_q   <= cfg_data;
					REG_GROUP: group_q <= cfg_data;
					REG_ETX:   etx_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			if (req_fire)
				k_q <= '0;
			else if (step_go && ctl.div_rem)
				k_q <= k_q + CNT_W'(1);
			else if (step_go && ctl.dig_dec)
				k_q <= k_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q   <= cmd_byte;
			addr_q  <= {ADDR_HI, addr_lo};
			start_q <= (channel < 8'd16) ? stx_q : group_q + {3'b000, grp};
			val_q   <= vclamp;
			ndig_q  <= dsat[CNT_W-1:0];
			check_q <= '0;
		end else if (step_go) begin
			if (ctl.div_mul)
				quot_q <= prod[RSHIFT+QUOT_W-1:RSHIFT];
			if (ctl.div_rem) begin
				digits_q[k_q[IDX_W-1:0]] <= rem;
				val_q <= {{(VAL_W-QUOT_W){1'b0}}, quot_q};
			end
			if (ctl.load_pair) begin
				pair_q  <= byte_out;
				check_q <= check_q ^ byte_out;
			end
			if (ctl.xor_etx)
				check_q <= check_q ^ etx_q;
		end
	end

	always_comb begin
		case (ctl.src)
			SRC_DELIM: byte_out = delim_q;
			SRC_START: byte_out = start_q;
			SRC_ADDR:  byte_out = addr_q;
			SRC_CMD:   byte_out = cmd_q;
			SRC_DIGIT: byte_out = {DIGIT_HI, digits_q[k_dec[IDX_W-1:0]]};
			SRC_PAIRC: byte_out = pair_q ^ COMP_MASK;
			SRC_ETX:   byte_out = etx_q;
			SRC_CHECK: byte_out = check_q | CHK_MARK;
			default:   byte_out = delim_q;
		endcase
	end

	always_comb begin
		stat.nodig    = (ndig_q == '0);
		stat.div_more = ({1'b0, k_q} + (CNT_W+1)'(1)) < {1'b0, ndig_q};
		stat.dig_more = (k_q != CNT_W'(1));
	end

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= CNT_W'(MAX_DIGITS))
		else $error("digit counter out of range");

	a_k_count: assert property (@(posedge clk) disable iff (!arst_n)
		(step_go && ctl.div_rem && !req_fire) |=> k_q == $past(k_q) + CNT_W'(1))
		else $error("digit counter missed an increment");

	a_k_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> k_q == '0)
		else $error("digit counter not cleared on request");

endmodule

`default_nettype wire

FILE: rtl/core/dispenser_command_frame_builder.sv
//------------------------------------------------------------------------------
// dispenser_command_frame_builder
// Builds a dispenser command frame from one request, one byte per transfer.
//------------------------------------------------------------------------------
// Sequence: after the request transfer the sequencer runs one multiply and one
//   remainder step per digit, then emits each byte through an output register.
// Frame length: 9+2*d byte steps with d digits, each stalled while the output
//   slot is full; the next request is taken only after the last byte step.
// Reset: arst_n clears the step counter and output valid flag and reloads the
//   config registers; the block is ready right after reset.
`default_nettype none

module dispenser_command_frame_builder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dcfb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dcfb_pkg::BYTE_W-1:0]    cfg_data,
	dcfb_req_if.sink                            req,
	dcfb_frame_if.source                        frame
);
	import dcfb_pkg::*;

	logic [PC_W-1:0]   pc_q;
	ctl_t              ctl;
	stat_t             stat;
	logic [BYTE_W-1:0] byte_nxt;
	logic              out_valid_q, out_last_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              req_fire, slot_free, step_go, emit_fire, jump;

	dcfb_ucode_rom u_rom (
		.pc  (pc_q),
		.ctl (ctl)
	);

	dcfb_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_fire     (req_fire),
		.channel      (req.channel),
		.cmd_byte     (req.cmd_byte),
		.value        (req.value),
		.digit_count  (req.digit_count),
		.ctl          (ctl),
		.step_go      (step_go),
		.byte_out     (byte_nxt),
		.stat         (stat)
	);

	assign req.ready = ctl.take_req;
	assign req_fire  = req.valid && ctl.take_req;
	assign slot_free = !out_valid_q || frame.ready;
	assign emit_fire = ctl.emit && slot_free;
	assign step_go   = ctl.take_req ? req_fire : (ctl.emit ? slot_free : 1'b1);

	always_comb begin
		unique case (ctl.jmp)
			JMP_NONE:     jump = 1'b0;
			JMP_ALWAYS:   jump = 1'b1;
			JMP_NODIG:    jump = stat.nodig;
			JMP_DIV_MORE: jump = stat.div_more;
			JMP_DIG_MORE: jump = stat.dig_more;
			default:      jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_WAIT;
			out_valid_q <= 1'b0;
		end else begin
			if (step_go)
				pc_q <= jump ? ctl.target : pc_q + PC_W'(1);
			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (frame.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_byte_q <= byte_nxt;
			out_last_q <= ctl.last;
		end
	end

	assign frame.valid         = out_valid_q;
	assign frame.frame_byte    = out_byte_q;
	assign frame.last_of_frame = out_last_q;

	a_req_start: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> pc_q == STEP_DIVM)
		else $error("sequencer did not start after request transfer");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && !slot_free) |=> $stable(pc_q))
		else $error("sequencer advanced while output slot was full");

	a_last_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && ctl.last) |=> pc_q == STEP_WAIT)
		else $error("sequencer did not return after last byte");

	a_last_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && ctl.last) |=> frame.valid && frame.last_of_frame)
		else $error("last byte not presented");

endmodule

`default_nettype wire
